### design/fsd_pkg.sv
// Shared types, constants and register indexes of the error-diffusion ditherer.
package fsd_pkg;

    localparam int DEF_MAX_LINE_WIDTH = 1024;
    localparam int DEF_ERROR_BITS     = 16;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_ORIGIN     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_ORIGIN     = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VERTICAL_FLIP = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_BITS     = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_BITS   = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_BITS    = 4'd7;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         flags;
        logic signed [15:0] raster_op;
    } t_pixel;

    typedef struct packed {
        logic [15:0]        column;
        logic [15:0]        row;
        logic [7:0]         red_code;
        logic [7:0]         green_code;
        logic [7:0]         blue_code;
        logic [7:0]         flags_out;
        logic signed [15:0] raster_op_out;
        logic               passed_through;
        logic               line_end;
    } t_result;

    typedef struct packed {
        logic [14:0] x_origin;
        logic [14:0] y_origin;
        logic [10:0] line_width;
        logic [14:0] image_height;
        logic        vertical_flip;
        logic [3:0]  red_bits;
        logic [3:0]  green_bits;
        logic [3:0]  blue_bits;
    } t_cfg;

    // Pixel after classification: placement is settled, dithering is not.
    typedef struct packed {
        t_pixel      pixel;
        logic [15:0] column;
        logic [15:0] row;
        logic        line_end;
    } t_job;

endpackage

### design/floyd_steinberg_rgb_ditherer_top.sv
// Top level of the Floyd-Steinberg RGB error-diffusion ditherer.
//
// Usage:
// - Pixel channel: present a pixel on i_pixel and raise push; the transfer
//   happens on a rising edge with push high and full low. Pixels arrive in
//   raster order, line_width pixels per line.
// - Result channel: while empty is low, o_result holds the oldest dithered
//   pixel; a transfer happens on a rising edge with pop high.
// - Config channel: one register per transfer (i_cfg_valid, o_cfg_ready always
//   high). Write only while the block is idle. Any write to a known index
//   clears the error line stores, the carries and the line position, and
//   reloads the start row; unknown indexes are dropped.
// - A pixel passes the classified-pixel queue, read and compute stages and the
//   output queue before empty goes low. Throughput: one pixel per cycle unless
//   stalled, set by the single read and write port of each of the two ping-pong
//   error line stores; the compute stage resolves the right-neighbor error.
// - Reset (i_rst_n low, synchronous) empties both queues and loads the
//   register defaults; the line stores need no clearing pass.
// - When the receiver stalls, results collect in a two-entry output queue,
//   then in the compute and read stages and a four-entry classified-pixel
//   queue; full rises once the classified-pixel queue is full.
module floyd_steinberg_rgb_ditherer_top #(
    parameter int MAX_LINE_WIDTH = fsd_pkg::DEF_MAX_LINE_WIDTH,
    parameter int ERROR_BITS     = fsd_pkg::DEF_ERROR_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  fsd_pkg::t_pixel                      i_pixel,
    output logic                                 full,
    input  logic                                 pop,
    output fsd_pkg::t_result                     o_result,
    output logic                                 empty,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fsd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [fsd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import fsd_pkg::*;

    localparam int PW = $clog2(MAX_LINE_WIDTH);
    localparam int QW = $bits(t_job) + PW;

    t_cfg          r_cfg;
    logic          cfg_write, clear;
    logic          q_push, q_full, q_pop, q_empty;
    t_job          f_job, b_job;
    logic [PW-1:0] f_pos, b_pos;
    logic [QW-1:0] q_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign full        = q_full;

    // Register writes; a known index also clears the run state.
    always_comb begin
        case (i_cfg_index)
            REG_X_ORIGIN, REG_Y_ORIGIN, REG_LINE_WIDTH, REG_IMAGE_HEIGHT,
            REG_VERTICAL_FLIP, REG_RED_BITS, REG_GREEN_BITS, REG_BLUE_BITS: begin
                clear = cfg_write;
            end
            default: begin
                clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin      <= '0;
            r_cfg.y_origin      <= '0;
            r_cfg.line_width    <= 11'd1;
            r_cfg.image_height  <= 15'd1;
            r_cfg.vertical_flip <= 1'b0;
            r_cfg.red_bits      <= 4'd5;
            r_cfg.green_bits    <= 4'd6;
            r_cfg.blue_bits     <= 4'd5;
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_X_ORIGIN: begin
                    r_cfg.x_origin <= i_cfg_data[14:0];
                end
                REG_Y_ORIGIN: begin
                    r_cfg.y_origin <= i_cfg_data[14:0];
                end
                REG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data[10:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[14:0];
                end
                REG_VERTICAL_FLIP: begin
                    r_cfg.vertical_flip <= i_cfg_data[0];
                end
                REG_RED_BITS: begin
                    r_cfg.red_bits <= i_cfg_data[3:0];
                end
                REG_GREEN_BITS: begin
                    r_cfg.green_bits <= i_cfg_data[3:0];
                end
                REG_BLUE_BITS: begin
                    r_cfg.blue_bits <= i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Classify: position, column, row and line end per pixel.
    fsd_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_clear  (clear),
        .i_push   (push),
        .i_pixel  (i_pixel),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_job    (f_job),
        .o_pos    (f_pos)
    );

    // Decouple classification from the error arithmetic.
    fsd_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_job, f_pos}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign b_job = q_rdata[QW-1:PW];
    assign b_pos = q_rdata[PW-1:0];

    // Diffuse error and quantize; results go out through the output queue.
    fsd_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .ERROR_BITS     (ERROR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clear   (clear),
        .i_q_empty (q_empty),
        .i_job     (b_job),
        .i_pos     (b_pos),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_result  (o_result),
        .o_empty   (empty)
    );
endmodule

### design/fsd_ram.sv
// Generic single-write, single-read RAM with registered, write-first read.
module fsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/fsd_fifo.sv
// Small register-based FIFO with push/full and pop/empty sides.
module fsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_store[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_store[r_wptr] <= i_data;
        end
    end
endmodule

### design/fsd_front.sv
// Front end: accepts pixels and assigns line position, column, row and line end.
module fsd_front #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fsd_pkg::t_cfg                     i_cfg,
    input  logic                              i_clear,
    input  logic                              i_push,
    input  fsd_pkg::t_pixel                   i_pixel,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output fsd_pkg::t_job                     o_job,
    output logic [$clog2(MAX_LINE_WIDTH)-1:0] o_pos
);
    import fsd_pkg::*;

    localparam int PW = $clog2(MAX_LINE_WIDTH);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_row, n_row;
    logic          r_row_valid, n_row_valid;
    logic [31:0]   w_eff;
    logic [15:0]   start_row, row_now;
    logic          last, accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    always_comb begin
        if (i_cfg.line_width == '0) begin
            w_eff = 32'd1;
        end else if (32'(i_cfg.line_width) > 32'(MAX_LINE_WIDTH)) begin
            w_eff = 32'(MAX_LINE_WIDTH);
        end else begin
            w_eff = 32'(i_cfg.line_width);
        end
        if (i_cfg.vertical_flip) begin
            start_row = 16'(i_cfg.y_origin) + 16'(i_cfg.image_height) - 16'd1;
        end else begin
            start_row = 16'(i_cfg.y_origin);
        end
        row_now = r_row_valid ? r_row : start_row;
        last    = (32'(r_pos) + 32'd1 == w_eff);

        o_job.pixel    = i_pixel;
        o_job.column   = 16'(i_cfg.x_origin) + 16'(r_pos);
        o_job.row      = row_now;
        o_job.line_end = last;
        o_pos          = r_pos;

        n_pos       = r_pos;
        n_row       = r_row;
        n_row_valid = r_row_valid;
        if (accept) begin
            n_row_valid = 1'b1;
            if (last) begin
                n_pos = '0;
                n_row = i_cfg.vertical_flip ? row_now - 16'd1 : row_now + 16'd1;
            end else begin
                n_pos = r_pos + 1'b1;
                n_row = row_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos       <= '0;
            r_row_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_row_valid <= n_row_valid;
        end
        r_row <= n_row;
    end
endmodule

### design/fsd_back.sv
// Back end: error line stores, diffusion arithmetic and the result queue.
module fsd_back #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int ERROR_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fsd_pkg::t_cfg                     i_cfg,
    input  logic                              i_clear,
    input  logic                              i_q_empty,
    input  fsd_pkg::t_job                     i_job,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_pos,
    output logic                              o_q_pop,
    input  logic                              i_pop,
    output fsd_pkg::t_result                  o_result,
    output logic                              o_empty
);
    import fsd_pkg::*;

    localparam int PW = $clog2(MAX_LINE_WIDTH);
    localparam int EB = ERROR_BITS;
    localparam int SW = ERROR_BITS + 4;
    localparam int RW = 3 * ERROR_BITS;
    localparam logic signed [SW-1:0] SAT_HI = $signed(SW'((64'sd1 <<< (EB - 1)) - 64'sd1));
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - $signed(SW'(1));

    function automatic logic signed [EB-1:0] sat(input logic signed [SW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[EB-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[EB-1:0];
        end
        return v[EB-1:0];
    endfunction

    function automatic logic [3:0] eff_bits(input logic [3:0] n);
        if (n == 4'd0) begin
            return 4'd1;
        end else if (n > 4'd8) begin
            return 4'd8;
        end
        return n;
    endfunction

    // Widen a truncated code back to 8 bits by bit replication.
    function automatic logic [7:0] expand(input logic [7:0] code, input logic [3:0] n);
        logic [7:0] x;
        logic [4:0] k;
        x = code << (4'd8 - n);
        k = {1'b0, n};
        for (int i = 0; i < 3; i++) begin
            if (k < 5'd8) begin
                x = x | (x >> k);
                k = k << 1;
            end
        end
        return x;
    endfunction

    // Read stage and compute stage registers.
    logic          r_rv, r_cv;
    t_job          r_rjob, r_cjob;
    logic [PW-1:0] r_rpos, r_cpos;
    logic          r_adv, c_fire, out_full;

    // Line store banks: r_bank is the one holding the current row.
    logic          r_bank, r_cur_zero;
    logic          r_pend_valid, r_pend_bank;
    logic [PW-1:0] r_pend_addr;
    logic [RW-1:0] r_pend_data;

    logic signed [EB-1:0] r_carry [3];
    logic signed [EB-1:0] r_bw0   [3];
    logic signed [9:0]    r_bw1   [3];

    logic [RW-1:0] rdata [2];
    logic          we    [2];
    logic [PW-1:0] waddr [2];
    logic [RW-1:0] wdata [2];

    logic [RW-1:0]        cur_word, nrow_word, bw0_word;
    logic signed [EB-1:0] carry_n [3];
    logic signed [EB-1:0] bw0_n   [3];
    logic signed [9:0]    e       [3];
    logic [7:0]           code    [3];
    logic [7:0]           pix     [3];
    logic [3:0]           nbits   [3];
    logic                 flagged, wr_main;
    logic [PW-1:0]        wr_addr;
    logic [RW-1:0]        wr_data;
    t_result              res;

    assign c_fire  = r_cv && !out_full;
    assign r_adv   = r_rv && (!r_cv || c_fire);
    assign o_q_pop = !i_q_empty && (!r_rv || r_adv);

    assign cur_word = r_cur_zero ? '0 : (r_bank ? rdata[1] : rdata[0]);
    assign flagged  = (r_cjob.pixel.flags != 8'd0);

    always_comb begin
        logic signed [EB-1:0] cur, acc1, acc2, vs;
        logic signed [SW-1:0] ew;
        logic [7:0]           vb;
        pix[0]   = r_cjob.pixel.red;
        pix[1]   = r_cjob.pixel.green;
        pix[2]   = r_cjob.pixel.blue;
        nbits[0] = eff_bits(i_cfg.red_bits);
        nbits[1] = eff_bits(i_cfg.green_bits);
        nbits[2] = eff_bits(i_cfg.blue_bits);
        for (int c = 0; c < 3; c++) begin
            cur  = cur_word[c*EB +: EB];
            acc1 = sat(SW'(cur) + SW'(r_carry[c]));
            acc2 = sat(SW'(acc1) + $signed(SW'({pix[c], 4'b0000})));
            vs   = acc2 >>> 4;
            if (vs < 0) begin
                vb = 8'd0;
            end else if (vs > 255) begin
                vb = 8'd255;
            end else begin
                vb = vs[7:0];
            end
            if (flagged) begin
                code[c]    = pix[c] >> (4'd8 - nbits[c]);
                e[c]       = '0;
                carry_n[c] = '0;
            end else begin
                code[c]    = vb >> (4'd8 - nbits[c]);
                e[c]       = $signed({2'b00, vb}) - $signed({2'b00, expand(code[c], nbits[c])});
                ew         = SW'(e[c]);
                carry_n[c] = sat((ew <<< 3) - ew);
            end
            ew = SW'(e[c]);
            nrow_word[c*EB +: EB] = sat(SW'(r_bw0[c]) + ew + (ew <<< 1));
            bw0_n[c]              = sat(SW'(r_bw1[c]) + ew + (ew <<< 2));
            bw0_word[c*EB +: EB]  = bw0_n[c];
        end

        // Below-left lands one column back; a one-pixel line writes its own column.
        wr_main = c_fire && ((r_cpos != '0) || r_cjob.line_end);
        wr_addr = (r_cpos != '0) ? r_cpos - 1'b1 : '0;
        wr_data = (r_cpos != '0) ? nrow_word : bw0_word;

        for (int b = 0; b < 2; b++) begin
            if (wr_main && (b[0] == !r_bank)) begin
                we[b]    = 1'b1;
                waddr[b] = wr_addr;
                wdata[b] = wr_data;
            end else begin
                we[b]    = r_pend_valid && (r_pend_bank == b[0]);
                waddr[b] = r_pend_addr;
                wdata[b] = r_pend_data;
            end
        end

        res.column         = r_cjob.column;
        res.row            = r_cjob.row;
        res.red_code       = code[0];
        res.green_code     = code[1];
        res.blue_code      = code[2];
        res.flags_out      = r_cjob.pixel.flags;
        res.raster_op_out  = r_cjob.pixel.raster_op;
        res.passed_through = flagged;
        res.line_end       = r_cjob.line_end;
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        fsd_ram #(
            .WIDTH (RW),
            .DEPTH (MAX_LINE_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[g]),
            .i_waddr (waddr[g]),
            .i_wdata (wdata[g]),
            .i_re    (r_adv),
            .i_raddr (r_rpos),
            .o_rdata (rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv         <= 1'b0;
            r_cv         <= 1'b0;
            r_bank       <= 1'b0;
            r_cur_zero   <= 1'b1;
            r_pend_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_carry[c] <= '0;
                r_bw0[c]   <= '0;
                r_bw1[c]   <= '0;
            end
        end else begin
            if (o_q_pop) begin
                r_rv <= 1'b1;
            end else if (r_adv) begin
                r_rv <= 1'b0;
            end
            if (r_adv) begin
                r_cv <= 1'b1;
            end else if (c_fire) begin
                r_cv <= 1'b0;
            end
            r_pend_valid <= c_fire && r_cjob.line_end && (r_cpos != '0);
            if (i_clear) begin
                r_cur_zero <= 1'b1;
                for (int c = 0; c < 3; c++) begin
                    r_carry[c] <= '0;
                    r_bw0[c]   <= '0;
                    r_bw1[c]   <= '0;
                end
            end else if (c_fire) begin
                if (r_cjob.line_end) begin
                    r_bank     <= !r_bank;
                    r_cur_zero <= 1'b0;
                    for (int c = 0; c < 3; c++) begin
                        r_carry[c] <= '0;
                        r_bw0[c]   <= '0;
                        r_bw1[c]   <= '0;
                    end
                end else begin
                    for (int c = 0; c < 3; c++) begin
                        r_carry[c] <= carry_n[c];
                        r_bw0[c]   <= bw0_n[c];
                        r_bw1[c]   <= e[c];
                    end
                end
            end
        end
        if (o_q_pop) begin
            r_rjob <= i_job;
            r_rpos <= i_pos;
        end
        if (r_adv) begin
            r_cjob <= r_rjob;
            r_cpos <= r_rpos;
        end
        r_pend_bank <= !r_bank;
        r_pend_addr <= r_cpos;
        r_pend_data <= bw0_word;
    end

    fsd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_fire),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );
endmodule
